// File: rtl/wvld_pkg.sv
// Shared types, codes and the waveform table of the wavetable voice.
`default_nettype none

package wvld_pkg;

    localparam int PHASE_FRAC_BITS = 16;
    localparam int INDEX_W         = 8;
    localparam int PHASE_W         = INDEX_W + PHASE_FRAC_BITS;
    localparam int LEVEL_W         = 15;
    localparam int TICK_W          = 16;
    localparam int WAVE_W          = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [LEVEL_W-1:0] PEAK_LEVEL_RESET = 15'd9830;
    localparam logic [LEVEL_W-1:0] DECAY_STEP_RESET = 15'd5;
    localparam logic [TICK_W-1:0]  FADE_TICKS_RESET = 16'd2000;
    localparam logic [PHASE_W-1:0] STEP_RESET       = 24'd380;

    typedef enum logic [1:0] {
        FUNC_SAMPLE  = 2'd0,
        FUNC_NOTE_ON = 2'd1,
        FUNC_TICK    = 2'd2
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PEAK_LEVEL = 2'd0,
        CFG_DECAY_STEP = 2'd1,
        CFG_FADE_TICKS = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [PHASE_W-1:0] step;
        logic [LEVEL_W-1:0] level;
        logic [TICK_W-1:0]  elapsed;
        logic               playing;
    } voice_t;

    localparam int VOICE_W = $bits(voice_t);

    typedef struct packed {
        logic [LEVEL_W-1:0] peak_level;
        logic [LEVEL_W-1:0] decay_step;
        logic [TICK_W-1:0]  fade_ticks;
    } cfg_t;

    typedef struct packed {
        logic                     valid;
        logic [LEVEL_W-1:0]       level;
        logic signed [WAVE_W-1:0] wave;
        logic                     active;
    } scale_req_t;

    typedef struct packed {
        logic signed [WAVE_W-1:0] sample;
        logic                     active;
    } out_res_t;

    localparam logic signed [WAVE_W-1:0] WAVE_ROM [0:255] = '{
        16'sd0, 16'sd1921, 16'sd3829, 16'sd5706, 16'sd7540, 16'sd9317, 16'sd11023, 16'sd12647,
        16'sd14178, 16'sd15605, 16'sd16921, 16'sd18119, 16'sd19191, 16'sd20135, 16'sd20948,
        16'sd21628,
        16'sd22177, 16'sd22595, 16'sd22886, 16'sd23055, 16'sd23107, 16'sd23049, 16'sd22890,
        16'sd22636,
        16'sd22299, 16'sd21888, 16'sd21412, 16'sd20882, 16'sd20309, 16'sd19703, 16'sd19072,
        16'sd18428,
        16'sd17778, 16'sd17132, 16'sd16496, 16'sd15878, 16'sd15282, 16'sd14714, 16'sd14179,
        16'sd13678,
        16'sd13214, 16'sd12787, 16'sd12399, 16'sd12048, 16'sd11733, 16'sd11453, 16'sd11203,
        16'sd10982,
        16'sd10786, 16'sd10610, 16'sd10452, 16'sd10307, 16'sd10171, 16'sd10040, 16'sd9911,
        16'sd9781,
        16'sd9646, 16'sd9504, 16'sd9352, 16'sd9190, 16'sd9015, 16'sd8828, 16'sd8628, 16'sd8416,
        16'sd8191, 16'sd7956, 16'sd7713, 16'sd7462, 16'sd7206, 16'sd6947, 16'sd6688, 16'sd6431,
        16'sd6179, 16'sd5933, 16'sd5697, 16'sd5472, 16'sd5260, 16'sd5063, 16'sd4881, 16'sd4715,
        16'sd4567, 16'sd4436, 16'sd4322, 16'sd4224, 16'sd4141, 16'sd4073, 16'sd4018, 16'sd3973,
        16'sd3938, 16'sd3910, 16'sd3886, 16'sd3866, 16'sd3846, 16'sd3825, 16'sd3801, 16'sd3772,
        16'sd3735, 16'sd3691, 16'sd3638, 16'sd3574, 16'sd3500, 16'sd3414, 16'sd3318, 16'sd3211,
        16'sd3094, 16'sd2967, 16'sd2832, 16'sd2689, 16'sd2541, 16'sd2388, 16'sd2232, 16'sd2074,
        16'sd1915, 16'sd1758, 16'sd1604, 16'sd1453, 16'sd1306, 16'sd1166, 16'sd1031, 16'sd903,
        16'sd781, 16'sd666, 16'sd557, 16'sd454, 16'sd357, 16'sd263, 16'sd173, 16'sd86,
        16'sd0, -16'sd86, -16'sd173, -16'sd263, -16'sd357, -16'sd454, -16'sd557, -16'sd666,
        -16'sd781, -16'sd903, -16'sd1031, -16'sd1166, -16'sd1306, -16'sd1453, -16'sd1604,
        -16'sd1758,
        -16'sd1915, -16'sd2074, -16'sd2232, -16'sd2388, -16'sd2541, -16'sd2689, -16'sd2832,
        -16'sd2967,
        -16'sd3094, -16'sd3211, -16'sd3318, -16'sd3414, -16'sd3500, -16'sd3574, -16'sd3638,
        -16'sd3691,
        -16'sd3735, -16'sd3772, -16'sd3801, -16'sd3825, -16'sd3846, -16'sd3866, -16'sd3886,
        -16'sd3910,
        -16'sd3938, -16'sd3973, -16'sd4018, -16'sd4073, -16'sd4141, -16'sd4224, -16'sd4322,
        -16'sd4436,
        -16'sd4567, -16'sd4715, -16'sd4881, -16'sd5063, -16'sd5260, -16'sd5472, -16'sd5697,
        -16'sd5933,
        -16'sd6179, -16'sd6431, -16'sd6688, -16'sd6947, -16'sd7206, -16'sd7462, -16'sd7713,
        -16'sd7956,
        -16'sd8191, -16'sd8416, -16'sd8628, -16'sd8828, -16'sd9015, -16'sd9190, -16'sd9352,
        -16'sd9504,
        -16'sd9646, -16'sd9781, -16'sd9911, -16'sd10040, -16'sd10171, -16'sd10307, -16'sd10452,
        -16'sd10610,
        -16'sd10786, -16'sd10982, -16'sd11203, -16'sd11453, -16'sd11733, -16'sd12048,
        -16'sd12399, -16'sd12787,
        -16'sd13214, -16'sd13678, -16'sd14179, -16'sd14714, -16'sd15282, -16'sd15878,
        -16'sd16496, -16'sd17132,
        -16'sd17778, -16'sd18428, -16'sd19072, -16'sd19703, -16'sd20309, -16'sd20882,
        -16'sd21412, -16'sd21888,
        -16'sd22299, -16'sd22636, -16'sd22890, -16'sd23049, -16'sd23107, -16'sd23055,
        -16'sd22886, -16'sd22595,
        -16'sd22177, -16'sd21628, -16'sd20948, -16'sd20135, -16'sd19191, -16'sd18119,
        -16'sd16921, -16'sd15605,
        -16'sd14178, -16'sd12647, -16'sd11023, -16'sd9317, -16'sd7540, -16'sd5706, -16'sd3829,
        -16'sd1921
    };

endpackage

`default_nettype wire

// File: rtl/wavetable_voice_linear_decay_unit.sv
// Top level of the one-voice wavetable oscillator with linear decay envelope.
//
// Input channel s_axis: tuser carries the command (sample request, note on,
// time tick), tdata the phase step used by note on. Output channel m_axis
// carries one result per sample request; note on and time tick return nothing.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge (0 peak level, 1 decay step, 2 fade ticks); other indexes are dropped.
// The voice state sits in a one-entry RAM; each item is read, updated and
// written back in the cycle after its transfer, with the last written value
// forwarded to the next item. One item is taken per cycle while s_axis_tready
// is high. A sample result passes the RAM read and update, the operand
// register and the multiply into the result queue before it reaches m_axis.
// A credit count of OUT_DEPTH results in flight bounds the input: when the
// receiver stalls the queue fills and s_axis_tready drops; with OUT_DEPTH of
// at least 4 a receiver that is always ready sees full rate.
// Reset clears the pipeline and the queue and restores the register defaults;
// the voice starts silent with phase zero.
`default_nettype none

module wavetable_voice_linear_decay_unit #(
    parameter int OUT_DEPTH = 4
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [23:0]                        s_axis_tdata,  // phase_step[23:0]
    input  wire logic [1:0]                         s_axis_tuser,  // func[1:0]
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [23:0]                             m_axis_tdata,  // sample[15:0], active[16], zero
    input  wire logic                               cfg_we,
    input  wire logic [wvld_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [wvld_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PEND_W = $clog2(OUT_DEPTH + 1);

    wvld_pkg::cfg_t       cfg_reg;
    logic [PEND_W-1:0]    pending_reg;
    logic [PEND_W-1:0]    pending_next;

    logic                 s_xfer;
    logic                 m_xfer;
    logic                 sample_xfer;
    wvld_pkg::scale_req_t req;
    logic                 res_valid;
    wvld_pkg::out_res_t   res;
    wvld_pkg::out_res_t   head;

    assign s_axis_tready = (pending_reg < PEND_W'(OUT_DEPTH));
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign m_xfer        = m_axis_tvalid && m_axis_tready;
    assign sample_xfer   = s_xfer && (s_axis_tuser == wvld_pkg::FUNC_SAMPLE);

    always_comb
    begin
        pending_next = pending_reg;
        if (sample_xfer && !m_xfer)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (m_xfer && !sample_xfer)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg        <= '0;
            cfg_reg.peak_level <= wvld_pkg::PEAK_LEVEL_RESET;
            cfg_reg.decay_step <= wvld_pkg::DECAY_STEP_RESET;
            cfg_reg.fade_ticks <= wvld_pkg::FADE_TICKS_RESET;
        end
        else
        begin
            pending_reg <= pending_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    wvld_pkg::CFG_PEAK_LEVEL:
                    begin
                        cfg_reg.peak_level <= cfg_data[wvld_pkg::LEVEL_W-1:0];
                    end
                    wvld_pkg::CFG_DECAY_STEP:
                    begin
                        cfg_reg.decay_step <= cfg_data[wvld_pkg::LEVEL_W-1:0];
                    end
                    wvld_pkg::CFG_FADE_TICKS:
                    begin
                        cfg_reg.fade_ticks <= cfg_data[wvld_pkg::TICK_W-1:0];
                    end
                    default:
                    begin
                        cfg_reg <= cfg_reg;
                    end
                endcase
            end
        end
    end

    wvld_voice u_voice (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_xfer  (s_xfer),
        .func       (s_axis_tuser),
        .phase_step (s_axis_tdata),
        .cfg        (cfg_reg),
        .req        (req)
    );

    wvld_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (res_valid),
        .res       (res)
    );

    wvld_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (m_xfer),
        .not_empty (m_axis_tvalid),
        .head      (head)
    );

    assign m_axis_tdata = {7'b0, head.active, head.sample};

endmodule

`default_nettype wire

// File: rtl/wvld_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module wvld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/wvld_voice.sv
// Voice state read-modify-write stage: state RAM, forwarding and update logic.
`default_nettype none

module wvld_voice (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 item_xfer,
    input  wire logic [1:0]                           func,
    input  wire logic [wvld_pkg::PHASE_W-1:0]         phase_step,
    input  wire wvld_pkg::cfg_t                       cfg,
    output wvld_pkg::scale_req_t                      req
);

    logic                              s1_valid_reg;
    wvld_pkg::func_t                   s1_func_reg;
    logic [wvld_pkg::PHASE_W-1:0]      s1_pstep_reg;
    logic                              fwd_reg;
    logic                              init_reg;
    wvld_pkg::voice_t                  wbuf_reg;

    logic [wvld_pkg::VOICE_W-1:0]      rdata;
    wvld_pkg::voice_t                  cur;
    wvld_pkg::voice_t                  nxt;
    logic [wvld_pkg::TICK_W:0]         tick_count;
    logic [wvld_pkg::INDEX_W-1:0]      idx;

    wvld_ram #(
        .WIDTH (wvld_pkg::VOICE_W),
        .DEPTH (1)
    ) u_state_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (1'b0),
        .wdata (nxt),
        .re    (1'b1),
        .raddr (1'b0),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            init_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= item_xfer;
            fwd_reg      <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                init_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            s1_func_reg  <= wvld_pkg::func_t'(func);
            s1_pstep_reg <= phase_step;
        end
        if (s1_valid_reg)
        begin
            wbuf_reg <= nxt;
        end
    end

    always_comb
    begin
        if (fwd_reg)
        begin
            cur = wbuf_reg;
        end
        else if (init_reg)
        begin
            cur = wvld_pkg::voice_t'(rdata);
        end
        else
        begin
            cur.phase   = '0;
            cur.step    = wvld_pkg::STEP_RESET;
            cur.level   = '0;
            cur.elapsed = '0;
            cur.playing = 1'b0;
        end
    end

    assign idx        = cur.phase[wvld_pkg::PHASE_W-1 -: wvld_pkg::INDEX_W];
    assign tick_count = {1'b0, cur.elapsed} + 17'd1;

    always_comb
    begin
        nxt        = cur;
        req.valid  = 1'b0;
        req.level  = cur.level;
        req.wave   = wvld_pkg::WAVE_ROM[idx];
        req.active = cur.playing;
        unique case (s1_func_reg)
            wvld_pkg::FUNC_SAMPLE:
            begin
                req.valid = s1_valid_reg;
                nxt.phase = cur.phase + cur.step;
            end
            wvld_pkg::FUNC_NOTE_ON:
            begin
                nxt.step    = s1_pstep_reg;
                nxt.level   = cfg.peak_level;
                nxt.elapsed = '0;
                nxt.playing = 1'b1;
            end
            wvld_pkg::FUNC_TICK:
            begin
                if (cur.playing)
                begin
                    if (tick_count > {1'b0, cfg.fade_ticks})
                    begin
                        nxt.level   = '0;
                        nxt.playing = 1'b0;
                    end
                    else if (cur.level > cfg.decay_step)
                    begin
                        nxt.level = cur.level - cfg.decay_step;
                    end
                    else
                    begin
                        nxt.level = '0;
                    end
                    nxt.elapsed = tick_count[wvld_pkg::TICK_W] ? {wvld_pkg::TICK_W{1'b1}}
                                                               : tick_count[wvld_pkg::TICK_W-1:0];
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/wvld_scale.sv
// Amplitude scaling stage: registered operands, one multiply, truncation toward zero.
`default_nettype none

module wvld_scale (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire wvld_pkg::scale_req_t req,
    output logic                      res_valid,
    output wvld_pkg::out_res_t        res
);

    logic                              s2_valid_reg;
    logic [wvld_pkg::LEVEL_W-1:0]      s2_level_reg;
    logic signed [wvld_pkg::WAVE_W-1:0] s2_wave_reg;
    logic                              s2_active_reg;

    logic [wvld_pkg::WAVE_W-1:0]       mag;
    logic [wvld_pkg::LEVEL_W+wvld_pkg::WAVE_W-1:0] prod;
    logic [wvld_pkg::WAVE_W-1:0]       quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            s2_level_reg  <= req.level;
            s2_wave_reg   <= req.wave;
            s2_active_reg <= req.active;
        end
    end

    assign mag  = s2_wave_reg[wvld_pkg::WAVE_W-1] ? (16'd0 - 16'(s2_wave_reg))
                                                  : 16'(s2_wave_reg);
    assign prod = 31'(s2_level_reg) * 31'(mag);
    assign quot = prod[wvld_pkg::LEVEL_W+wvld_pkg::WAVE_W-1 -: wvld_pkg::WAVE_W];

    assign res_valid  = s2_valid_reg;
    assign res.sample = s2_wave_reg[wvld_pkg::WAVE_W-1] ? $signed(16'd0 - quot) : $signed(quot);
    assign res.active = s2_active_reg;

endmodule

`default_nettype wire

// File: rtl/wvld_fifo.sv
// Result queue between the scaling stage and the output channel.
`default_nettype none

module wvld_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire wvld_pkg::out_res_t push_data,
    input  wire logic               pop,
    output logic                    not_empty,
    output wvld_pkg::out_res_t      head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    wvld_pkg::out_res_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// File: sim/tb_wavetable_voice_linear_decay_unit.sv
// Testbench for the wavetable voice: predicts each sample result and checks the output stream.
`timescale 1ns / 1ps

module tb_wavetable_voice_linear_decay_unit;

    localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
    localparam logic [1:0]  CFG_UNUSED   = 2'd3;
    localparam logic [23:0] DEFAULT_STEP = 24'((1 << 24) / 44100);
    localparam int          SETTLE_CYCLES = 8;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;  // phase_step[23:0]
    logic [1:0]  s_axis_tuser  = '0;  // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // sample[15:0], active[16], zero
    logic        cfg_we        = 1'b0;
    logic [wvld_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [wvld_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    int send_idle_pct = 23;
    int recv_idle_pct = 78;
    int fail_count    = 0;

    // voice and register model
    logic [wvld_pkg::PHASE_W-1:0] voice_phase   = '0;
    logic [wvld_pkg::PHASE_W-1:0] voice_step    = DEFAULT_STEP;
    logic [wvld_pkg::LEVEL_W-1:0] voice_level   = '0;
    logic [wvld_pkg::TICK_W-1:0]  voice_elapsed = '0;
    logic                         voice_playing = 1'b0;
    logic [wvld_pkg::LEVEL_W-1:0] peak_level    = wvld_pkg::PEAK_LEVEL_RESET;
    logic [wvld_pkg::LEVEL_W-1:0] decay_step    = wvld_pkg::DECAY_STEP_RESET;
    logic [wvld_pkg::TICK_W-1:0]  fade_ticks    = wvld_pkg::FADE_TICKS_RESET;

    wvld_pkg::out_res_t expected_samples[$];

    wavetable_voice_linear_decay_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void advance_voice(input logic [1:0] func, input logic [23:0] pstep);
        int                 wave;
        int                 mag;
        int                 scaled;
        wvld_pkg::out_res_t res;
        logic [16:0]        tick_count;
        case (func)
            wvld_pkg::FUNC_SAMPLE:
            begin
                wave   = int'(wvld_pkg::WAVE_ROM[
                             voice_phase[wvld_pkg::PHASE_W-1:wvld_pkg::PHASE_FRAC_BITS]]);
                mag    = (wave < 0) ? -wave : wave;
                scaled = (int'(voice_level) * mag) >>> 15;
                res.sample = 16'((wave < 0) ? -scaled : scaled);
                res.active = voice_playing;
                expected_samples.push_back(res);
                voice_phase = voice_phase + voice_step;
            end
            wvld_pkg::FUNC_NOTE_ON:
            begin
                voice_step    = pstep;
                voice_level   = peak_level;
                voice_elapsed = '0;
                voice_playing = 1'b1;
            end
            wvld_pkg::FUNC_TICK:
            begin
                if (voice_playing)
                begin
                    tick_count = {1'b0, voice_elapsed} + 17'd1;
                    if (tick_count > {1'b0, fade_ticks})
                    begin
                        voice_level   = '0;
                        voice_playing = 1'b0;
                    end
                    else
                    begin
                        voice_level = (voice_level > decay_step) ? voice_level - decay_step : '0;
                    end
                    voice_elapsed = tick_count[16] ? 16'hFFFF : tick_count[15:0];
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        wvld_pkg::out_res_t want;
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: sample %0d active %0b",
                             $signed(m_axis_tdata[15:0]), m_axis_tdata[16]);
            end
            else
            begin
                want = expected_samples.pop_front();
                if (m_axis_tdata[15:0] !== want.sample || m_axis_tdata[16] !== want.active)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: expected sample %0d active %0b, ",
                                  "got sample %0d active %0b"},
                                 want.sample, want.active,
                                 $signed(m_axis_tdata[15:0]), m_axis_tdata[16]);
                end
            end
        end
    end

    task automatic send_item(input logic [1:0] func, input logic [23:0] pstep);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= pstep;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        advance_voice(func, pstep);
    endtask

    // drop valid, drain all sample results, then let ticks and note-ons retire
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            wvld_pkg::CFG_PEAK_LEVEL: peak_level = value[14:0];
            wvld_pkg::CFG_DECAY_STEP: decay_step = value[14:0];
            wvld_pkg::CFG_FADE_TICKS: fade_ticks = value;
            default:
            begin
            end
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_voice(input int peak, input int decay, input int fade);
        settle();
        write_reg(wvld_pkg::CFG_PEAK_LEVEL, 16'(peak));
        write_reg(wvld_pkg::CFG_DECAY_STEP, 16'(decay));
        write_reg(wvld_pkg::CFG_FADE_TICKS, 16'(fade));
    endtask

    task automatic test_after_reset();
        send_item(wvld_pkg::FUNC_SAMPLE, 24'h000000);
        send_item(wvld_pkg::FUNC_SAMPLE, 24'hFFFFFF);
        send_item(wvld_pkg::FUNC_TICK, 24'hFFFFFF);
        send_item(FUNC_UNUSED, 24'h000000);
        send_item(wvld_pkg::FUNC_SAMPLE, 24'h5A5A5A);
    endtask

    task automatic test_note_and_decay();
        send_item(wvld_pkg::FUNC_NOTE_ON, 24'hFFFFFF);
        send_item(wvld_pkg::FUNC_SAMPLE, 24'h000000);
        send_item(wvld_pkg::FUNC_SAMPLE, 24'h000000);
        send_item(wvld_pkg::FUNC_TICK, 24'h000000);
        send_item(wvld_pkg::FUNC_TICK, 24'hFFFFFF);
        send_item(FUNC_UNUSED, 24'hFFFFFF);
        send_item(wvld_pkg::FUNC_SAMPLE, 24'hA5A5A5);
    endtask

    task automatic test_register_extremes();
        // zero fade length: the first tick silences the voice
        program_voice(32767, 0, 0);
        send_item(wvld_pkg::FUNC_NOTE_ON, 24'h140000);
        send_item(wvld_pkg::FUNC_SAMPLE, 24'h000000);
        send_item(wvld_pkg::FUNC_TICK, 24'h000000);
        send_item(wvld_pkg::FUNC_SAMPLE, 24'h000000);
        send_item(wvld_pkg::FUNC_TICK, 24'h000000);
        send_item(wvld_pkg::FUNC_SAMPLE, 24'h000000);
        // decay equal to the level: saturate at zero while still active
        program_voice(32767, 32767, 65535);
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_item(wvld_pkg::FUNC_NOTE_ON, 24'h000000);
        send_item(wvld_pkg::FUNC_SAMPLE, 24'h000000);
        send_item(wvld_pkg::FUNC_TICK, 24'h000000);
        send_item(wvld_pkg::FUNC_SAMPLE, 24'h000000);
        send_item(wvld_pkg::FUNC_SAMPLE, 24'h000000);
    endtask

    task automatic test_random_voice(input int peak, input int decay, input int fade,
                                     input int count);
        int          pick;
        logic [23:0] pstep;
        program_voice(peak, decay, fade);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            case ($urandom_range(2))
                0: pstep = 24'($urandom);
                1: pstep = 24'($urandom_range(24'h03FFFF));
                default: pstep = {8'($urandom), 16'h0000};
            endcase
            if (pick < 48)
                send_item(wvld_pkg::FUNC_SAMPLE, 24'($urandom));
            else if (pick < 83)
                send_item(wvld_pkg::FUNC_TICK, 24'($urandom));
            else if (pick < 95)
                send_item(wvld_pkg::FUNC_NOTE_ON, pstep);
            else
                send_item(FUNC_UNUSED, pstep);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_note_and_decay();
        test_register_extremes();
        test_random_voice(32767, 2000, 20, 310);
        test_random_voice(0, 0, 65535, 310);
        send_idle_pct = 78;
        recv_idle_pct = 23;
        test_random_voice($urandom_range(32767), $urandom_range(3000), $urandom_range(80, 1),
                          310);
        test_random_voice(32767, 32767, 1, 310);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_voice(20000, 1, 40, 310);
        test_random_voice($urandom_range(32767), $urandom_range(1500), $urandom_range(60, 1),
                          310);
        settle();
        if (fail_count == 0)
            $display("** wavetable_voice_linear_decay_unit: PASSED **");
        else
            $display("** wavetable_voice_linear_decay_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("** wavetable_voice_linear_decay_unit: FAILED **");
        $finish;
    end

endmodule

// File: wavetable_voice_linear_decay_unit.f
rtl/wvld_pkg.sv
rtl/wvld_ram.sv
rtl/wvld_voice.sv
rtl/wvld_scale.sv
rtl/wvld_fifo.sv
rtl/wavetable_voice_linear_decay_unit.sv
sim/tb_wavetable_voice_linear_decay_unit.sv
